>>> rtl/core/rbasp_pkg.sv
// ----------------------------------------------------------------------------
// rbasp_pkg
// shared types and constants of the bulk/array stream parser
// ----------------------------------------------------------------------------
package rbasp_pkg;

    localparam int MAX_DEPTH_DEF = 16;
    localparam logic [31:0] BULK_LIMIT_RST  = 32'd536870912;
    localparam logic [31:0] ARRAY_LIMIT_RST = 32'd1048576;
    localparam logic [33:0] ACCUM_CAP = 34'h2_0000_0000;
    localparam logic [33:0] ACCUM_CAP_DIV10 = 34'd858993459;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [0:0] REG_BULK_LIMIT  = 1'd0;
    localparam logic [0:0] REG_ARRAY_LIMIT = 1'd1;

    typedef enum logic [2:0] {
        K_NONE    = 3'd0,
        K_PAYLOAD = 3'd1,
        K_BULK    = 3'd2,
        K_NULL    = 3'd3,
        K_ARRAY   = 3'd4,
        K_BULKEND = 3'd5,
        K_ERROR   = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        E_TYPE      = 3'd0,
        E_BAD_BULK  = 3'd1,
        E_BULK_LONG = 3'd2,
        E_DEEP      = 3'd3,
        E_BAD_ARR   = 3'd4,
        E_ARR_LONG  = 3'd5,
        E_UNTERM    = 3'd6
    } t_err;

    typedef enum logic [2:0] {
        PH_TYPE    = 3'd0,
        PH_LINE    = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_TERM_CR = 3'd3,
        PH_TERM_LF = 3'd4,
        PH_HALT    = 3'd5
    } t_phase;

    // classified byte handed from the front part to the back part
    typedef struct packed {
        logic [7:0] data;
        logic       is_cr;
        logic       is_lf;
        logic       is_minus;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_dollar;
        logic       is_star;
    } t_cls;

endpackage

>>> rtl/core/rbasp_front.sv
// ----------------------------------------------------------------------------
// rbasp_front
// accepts bytes, classifies them and queues them for the back part
// ----------------------------------------------------------------------------
module rbasp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_byte_in,
    output logic             o_q_valid,
    input  logic             i_q_take,
    output rbasp_pkg::t_cls  o_q_data
);

    rbasp_pkg::t_cls r_q [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    rbasp_pkg::t_cls w_cls;
    logic            w_push, w_pop;

    always_comb begin
        w_cls.data      = i_byte_in;
        w_cls.is_cr     = (i_byte_in == rbasp_pkg::CH_CR);
        w_cls.is_lf     = (i_byte_in == rbasp_pkg::CH_LF);
        w_cls.is_minus  = (i_byte_in == rbasp_pkg::CH_MINUS);
        w_cls.is_digit  = (i_byte_in >= rbasp_pkg::CH_ZERO) &&
                          (i_byte_in <= rbasp_pkg::CH_NINE);
        w_cls.digit     = 4'(i_byte_in - rbasp_pkg::CH_ZERO);
        w_cls.is_dollar = (i_byte_in == rbasp_pkg::CH_DOLLAR);
        w_cls.is_star   = (i_byte_in == rbasp_pkg::CH_STAR);
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign w_pop     = o_q_valid && i_q_take;
    assign o_q_data  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd0 |=> r_cnt <= 2'd1) else $error("pop from empty queue");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> o_stall) else $error("full queue not stalling");

endmodule

>>> rtl/core/rbasp_back.sv
// ----------------------------------------------------------------------------
// rbasp_back
// parser state, element count stack and registered result
// ----------------------------------------------------------------------------
module rbasp_back #(
    parameter int MAX_DEPTH = rbasp_pkg::MAX_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    output logic             o_q_take,
    input  rbasp_pkg::t_cls  i_q_data,
    input  logic [31:0]      i_bulk_limit,
    input  logic [31:0]      i_array_limit,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [2:0]       o_event_kind,
    output logic [31:0]      o_event_value,
    output logic [4:0]       o_nest_level,
    output logic             o_message_done,
    output logic [2:0]       o_error_code
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);

    rbasp_pkg::t_phase r_ph, n_ph;
    logic        r_arr, n_arr;
    logic [33:0] r_acc, n_acc;
    logic        r_minus, n_minus, r_dig, n_dig, r_bad, n_bad, r_pcr, n_pcr;
    logic [31:0] r_left, n_left;
    logic        r_tbad, n_tbad;
    logic [DW-1:0] r_depth, n_depth;
    logic [31:0] r_cnt [MAX_DEPTH];
    logic [MAX_DEPTH-1:0] r_one;
    // pending element completion, resolved one closing array per cycle
    logic        r_close, n_close;
    logic        w_done_req;
    // every open array is on its last element
    logic        w_all_one;

    logic        r_ov;
    logic [2:0]  r_kind, n_kind;
    logic [31:0] r_val, n_val;
    logic [4:0]  r_lvl, n_lvl;
    logic        r_mdone, n_mdone;
    logic [2:0]  r_err, n_err;

    logic        w_fire, w_out_free;
    logic        w_wr_cnt;
    logic [31:0] w_wr_val;
    logic [33:0] w_mul;
    logic        w_valid_line;
    logic [AW-1:0] w_top;
    rbasp_pkg::t_cls c;

    assign c = i_q_data;
    assign w_out_free = !r_ov || !i_stall;
    assign o_q_take = i_q_valid && w_out_free && !r_close;
    assign w_fire = o_q_take;
    assign w_top = AW'(r_depth - DW'(1));
    assign w_mul = (r_acc << 3) + (r_acc << 1) + 34'(c.digit);
    assign w_valid_line = !r_bad && r_dig;

    always_comb begin
        w_all_one = 1'b1;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            if (DW'(i) < r_depth && !r_one[i]) w_all_one = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_ph = r_ph; n_arr = r_arr; n_acc = r_acc; n_minus = r_minus;
        n_dig = r_dig; n_bad = r_bad; n_pcr = r_pcr; n_left = r_left;
        n_tbad = r_tbad; n_depth = r_depth; n_close = 1'b0;
        w_wr_cnt = 1'b0; w_wr_val = 32'(r_acc);
        w_done_req = 1'b0;
        if (r_close) begin
            if (r_depth != DW'(0) && r_one[w_top]) begin
                n_depth = r_depth - DW'(1);
                n_close = 1'b1;
            end
        end else if (w_fire) begin
            case (r_ph)
                rbasp_pkg::PH_TYPE: begin
                    if (c.is_dollar || (c.is_star && r_depth < DEPTH_MAX)) begin
                        n_arr = c.is_star; n_acc = '0; n_minus = 1'b0;
                        n_dig = 1'b0; n_bad = 1'b0; n_pcr = 1'b0;
                        n_ph = rbasp_pkg::PH_LINE;
                    end else begin
                        n_ph = rbasp_pkg::PH_HALT;
                    end
                end
                rbasp_pkg::PH_LINE: begin
                    if (c.is_lf && r_pcr) begin
                        n_ph = rbasp_pkg::PH_TYPE;
                        if (!r_arr) begin
                            if (!w_valid_line || (r_minus && r_acc > 34'd1))
                                n_ph = rbasp_pkg::PH_HALT;
                            else if (r_minus && r_acc == 34'd1)
                                w_done_req = 1'b1;
                            else if (r_acc > 34'(i_bulk_limit))
                                n_ph = rbasp_pkg::PH_HALT;
                            else begin
                                n_left = 32'(r_acc);
                                n_tbad = 1'b0;
                                n_ph = (r_acc != 34'd0) ? rbasp_pkg::PH_PAYLOAD
                                                        : rbasp_pkg::PH_TERM_CR;
                            end
                        end else begin
                            if (!w_valid_line || (r_minus && r_acc != 34'd0) ||
                                r_acc > 34'(i_array_limit))
                                n_ph = rbasp_pkg::PH_HALT;
                            else if (r_acc == 34'd0)
                                w_done_req = 1'b1;
                            else begin
                                w_wr_cnt = 1'b1;
                                n_depth = r_depth + DW'(1);
                            end
                        end
                    end else if (c.is_cr) begin
                        if (r_pcr) n_bad = 1'b1;
                        n_pcr = 1'b1;
                    end else if (c.is_lf) begin
                        n_bad = 1'b1;
                    end else begin
                        if (r_pcr) begin
                            n_bad = 1'b1; n_pcr = 1'b0;
                        end
                        if (c.is_minus) begin
                            if (r_minus || r_dig) n_bad = 1'b1;
                            n_minus = 1'b1;
                        end else if (c.is_digit) begin
                            n_dig = 1'b1;
                            if (r_acc > rbasp_pkg::ACCUM_CAP_DIV10 ||
                                w_mul > rbasp_pkg::ACCUM_CAP)
                                n_acc = rbasp_pkg::ACCUM_CAP;
                            else
                                n_acc = w_mul;
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                end
                rbasp_pkg::PH_PAYLOAD: begin
                    n_left = r_left - 32'd1;
                    if (r_left == 32'd1) n_ph = rbasp_pkg::PH_TERM_CR;
                end
                rbasp_pkg::PH_TERM_CR: begin
                    n_tbad = !c.is_cr;
                    n_ph = rbasp_pkg::PH_TERM_LF;
                end
                rbasp_pkg::PH_TERM_LF: begin
                    if (r_tbad || !c.is_lf) n_ph = rbasp_pkg::PH_HALT;
                    else begin
                        n_ph = rbasp_pkg::PH_TYPE;
                        w_done_req = 1'b1;
                    end
                end
                default: ;
            endcase
            if (w_done_req && r_depth != DW'(0)) begin
                n_close = r_one[w_top];
                if (r_one[w_top]) n_depth = r_depth - DW'(1);
            end
        end
    end

    // result
    always_comb begin
        n_kind = 3'(rbasp_pkg::K_NONE); n_val = '0; n_lvl = 5'(r_depth);
        n_mdone = 1'b0; n_err = '0;
        case (r_ph)
            rbasp_pkg::PH_TYPE: begin
                if (!c.is_dollar && !c.is_star) begin
                    n_kind = 3'(rbasp_pkg::K_ERROR); n_err = 3'(rbasp_pkg::E_TYPE);
                end else if (c.is_star && r_depth >= DEPTH_MAX) begin
                    n_kind = 3'(rbasp_pkg::K_ERROR); n_err = 3'(rbasp_pkg::E_DEEP);
                end
            end
            rbasp_pkg::PH_LINE: begin
                if (c.is_lf && r_pcr) begin
                    if (!r_arr) begin
                        if (!w_valid_line || (r_minus && r_acc > 34'd1)) begin
                            n_kind = 3'(rbasp_pkg::K_ERROR);
                            n_err = 3'(rbasp_pkg::E_BAD_BULK);
                        end else if (r_minus && r_acc == 34'd1) begin
                            n_kind = 3'(rbasp_pkg::K_NULL);
                        end else if (r_acc > 34'(i_bulk_limit)) begin
                            n_kind = 3'(rbasp_pkg::K_ERROR);
                            n_err = 3'(rbasp_pkg::E_BULK_LONG);
                        end else begin
                            n_kind = 3'(rbasp_pkg::K_BULK); n_val = 32'(r_acc);
                        end
                    end else begin
                        if (!w_valid_line || (r_minus && r_acc != 34'd0)) begin
                            n_kind = 3'(rbasp_pkg::K_ERROR);
                            n_err = 3'(rbasp_pkg::E_BAD_ARR);
                        end else if (r_acc > 34'(i_array_limit)) begin
                            n_kind = 3'(rbasp_pkg::K_ERROR);
                            n_err = 3'(rbasp_pkg::E_ARR_LONG);
                        end else begin
                            n_kind = 3'(rbasp_pkg::K_ARRAY); n_val = 32'(r_acc);
                        end
                    end
                end
            end
            rbasp_pkg::PH_PAYLOAD: begin
                n_kind = 3'(rbasp_pkg::K_PAYLOAD); n_val = 32'(c.data);
            end
            rbasp_pkg::PH_TERM_LF: begin
                if (r_tbad || !c.is_lf) begin
                    n_kind = 3'(rbasp_pkg::K_ERROR); n_err = 3'(rbasp_pkg::E_UNTERM);
                end else begin
                    n_kind = 3'(rbasp_pkg::K_BULKEND);
                end
            end
            rbasp_pkg::PH_HALT: n_lvl = '0;
            default: ;
        endcase
        if (r_ph != rbasp_pkg::PH_PAYLOAD && r_ph != rbasp_pkg::PH_HALT &&
            n_kind == 3'(rbasp_pkg::K_NONE))
            n_lvl = (r_ph == rbasp_pkg::PH_TYPE) ? 5'(r_depth) : 5'(r_depth);
        n_mdone = w_done_req && w_all_one;
    end

    // element count stack
    always_ff @(posedge i_clk) begin
        if (w_wr_cnt) begin
            r_cnt[AW'(r_depth)] <= w_wr_val;
            r_one[AW'(r_depth)] <= (w_wr_val == 32'd1);
        end else if ((w_done_req || r_close) && r_depth != DW'(0)) begin
            r_cnt[w_top] <= r_cnt[w_top] - 32'd1;
            r_one[w_top] <= (r_cnt[w_top] == 32'd2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= rbasp_pkg::PH_TYPE;
            r_arr <= 1'b0; r_acc <= '0; r_minus <= 1'b0; r_dig <= 1'b0;
            r_bad <= 1'b0; r_pcr <= 1'b0; r_left <= '0; r_tbad <= 1'b0;
            r_depth <= '0; r_close <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_ph <= n_ph; r_arr <= n_arr; r_acc <= n_acc; r_minus <= n_minus;
            r_dig <= n_dig; r_bad <= n_bad; r_pcr <= n_pcr; r_left <= n_left;
            r_tbad <= n_tbad; r_depth <= n_depth; r_close <= n_close;
            if (w_fire) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_kind <= n_kind; r_val <= n_val; r_lvl <= n_lvl;
            r_err <= n_err; r_mdone <= n_mdone;
        end
    end

    assign o_valid        = r_ov;
    assign o_event_kind   = r_kind;
    assign o_event_value  = r_val;
    assign o_nest_level   = r_lvl;
    assign o_message_done = r_mdone;
    assign o_error_code   = r_err;

    a_depth_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_MAX) else $error("nesting depth beyond limit");
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ph == rbasp_pkg::PH_HALT |=> r_ph == rbasp_pkg::PH_HALT)
        else $error("left halt without reset");
    a_close_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_close |-> !o_q_take) else $error("byte taken during close");

endmodule

>>> rtl/core/resp_bulk_array_stream_parser.sv
// ----------------------------------------------------------------------------
// resp_bulk_array_stream_parser
// streaming parser for bulk strings and nested arrays, one result per byte
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the output is not held and no array is
// closing, and its result is registered in the output register. When an
// element completes and enclosing arrays close, the parser walks the element
// count stack one level at a time and takes no byte while it does so. A
// two-entry queue separates byte intake from the parser, and an output
// register holds each result until it is taken.
module resp_bulk_array_stream_parser #(
    parameter int MAX_DEPTH = rbasp_pkg::MAX_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_in,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_event_kind,
    output logic [31:0] o_event_value,
    output logic [4:0]  o_nest_level,
    output logic        o_message_done,
    output logic [2:0]  o_error_code
);

    logic [31:0]     r_bulk_limit, r_array_limit;
    logic            w_q_valid, w_q_take;
    rbasp_pkg::t_cls w_q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bulk_limit  <= rbasp_pkg::BULK_LIMIT_RST;
            r_array_limit <= rbasp_pkg::ARRAY_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rbasp_pkg::REG_BULK_LIMIT:  r_bulk_limit  <= i_cfg_data;
                rbasp_pkg::REG_ARRAY_LIMIT: r_array_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rbasp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_byte_in (i_byte_in),
        .o_q_valid (w_q_valid),
        .i_q_take  (w_q_take),
        .o_q_data  (w_q_data)
    );

    rbasp_back #(.MAX_DEPTH(MAX_DEPTH)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .o_q_take       (w_q_take),
        .i_q_data       (w_q_data),
        .i_bulk_limit   (r_bulk_limit),
        .i_array_limit  (r_array_limit),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_event_kind   (o_event_kind),
        .o_event_value  (o_event_value),
        .o_nest_level   (o_nest_level),
        .o_message_done (o_message_done),
        .o_error_code   (o_error_code)
    );

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// testbench of the bulk string / nested array stream parser
// ----------------------------------------------------------------------------
// Byte streams of well-formed messages with random content are sent through
// the parser under random idling on both sides and several limit settings.
// Each accepted byte is run through a behavioral copy of the parser and the
// predicted event is compared field by field with the event the block gives.
// The run ends on one randomly chosen error, after which the parser halts.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH     = rbasp_pkg::MAX_DEPTH_DEF;
    localparam int CYC_LIMIT = 300000;
    localparam int HOLD_CYC  = 300;

    typedef struct packed {
        rbasp_pkg::t_kind kind;
        logic [31:0]      value;
        logic [4:0]       level;
        logic             done;
        rbasp_pkg::t_err  err;
    } t_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_byte_in = 8'd0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = rbasp_pkg::REG_BULK_LIMIT;
    logic [31:0] i_cfg_data = 32'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_event_kind;
    logic [31:0] o_event_value;
    logic [4:0]  o_nest_level;
    logic        o_message_done;
    logic [2:0]  o_error_code;

    resp_bulk_array_stream_parser uut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // parser copy
    logic [31:0]       lim_bulk = rbasp_pkg::BULK_LIMIT_RST;
    logic [31:0]       lim_array = rbasp_pkg::ARRAY_LIMIT_RST;
    rbasp_pkg::t_phase ps_phase = rbasp_pkg::PH_TYPE;
    logic              ps_is_array = 1'b0;
    logic              ps_minus = 1'b0;
    logic              ps_digit = 1'b0;
    logic              ps_bad = 1'b0;
    logic              ps_cr = 1'b0;
    logic              ps_term_bad = 1'b0;
    logic              ps_halted = 1'b0;
    logic [33:0]       ps_accum = '0;
    logic [31:0]       ps_left = '0;
    logic [4:0]        ps_depth = '0;
    logic [31:0]       ps_counts [DEPTH] = '{default: '0};

    t_event     events_due [$];
    logic [7:0] bytes_out [$];
    int         err_cnt = 0;
    int         cyc = 0;
    int         sent_cnt = 0;
    int         took_cnt = 0;
    bit         quiet = 0;
    int         snd_gap = 0;
    int         rcv_gap = 0;
    bit         hold_on = 0;
    event       hold_go;

    task automatic post(rbasp_pkg::t_kind k, logic [31:0] v, logic [4:0] l, logic d,
                        rbasp_pkg::t_err e);
        t_event ev;
        ev.kind = k; ev.value = v; ev.level = l; ev.done = d; ev.err = e;
        events_due = {events_due, ev};
    endtask

    task automatic post_err(rbasp_pkg::t_err e);
        ps_halted = 1'b1;
        post(rbasp_pkg::K_ERROR, 32'd0, ps_depth, 1'b0, e);
    endtask

    function automatic logic close_elements();
        while (ps_depth != 5'd0) begin
            ps_counts[4'(ps_depth - 5'd1)] = ps_counts[4'(ps_depth - 5'd1)] - 32'd1;
            if (ps_counts[4'(ps_depth - 5'd1)] != 32'd0) return 1'b0;
            ps_depth = ps_depth - 5'd1;
        end
        return 1'b1;
    endfunction

    task automatic end_line();
        logic       ok;
        logic [4:0] lvl;
        logic       d;
        ok = !ps_bad && ps_digit;
        lvl = ps_depth;
        ps_phase = rbasp_pkg::PH_TYPE;
        if (!ps_is_array) begin
            if (!ok || (ps_minus && ps_accum > 34'd1)) post_err(rbasp_pkg::E_BAD_BULK);
            else if (ps_minus && ps_accum == 34'd1) begin
                d = close_elements();
                post(rbasp_pkg::K_NULL, 32'd0, lvl, d, rbasp_pkg::E_TYPE);
            end else if (ps_accum > {2'b00, lim_bulk}) post_err(rbasp_pkg::E_BULK_LONG);
            else begin
                ps_left = ps_accum[31:0];
                ps_term_bad = 1'b0;
                ps_phase = (ps_left != 32'd0) ? rbasp_pkg::PH_PAYLOAD
                                              : rbasp_pkg::PH_TERM_CR;
                post(rbasp_pkg::K_BULK, ps_accum[31:0], lvl, 1'b0, rbasp_pkg::E_TYPE);
            end
        end else begin
            if (!ok || (ps_minus && ps_accum != 34'd0)) post_err(rbasp_pkg::E_BAD_ARR);
            else if (ps_accum > {2'b00, lim_array}) post_err(rbasp_pkg::E_ARR_LONG);
            else if (ps_accum == 34'd0) begin
                d = close_elements();
                post(rbasp_pkg::K_ARRAY, 32'd0, lvl, d, rbasp_pkg::E_TYPE);
            end else begin
                ps_counts[4'(ps_depth)] = ps_accum[31:0];
                ps_depth = ps_depth + 5'd1;
                post(rbasp_pkg::K_ARRAY, ps_accum[31:0], lvl, 1'b0, rbasp_pkg::E_TYPE);
            end
        end
    endtask

    task automatic line_char(logic [7:0] b);
        if (b == rbasp_pkg::CH_CR) begin
            if (ps_cr) ps_bad = 1'b1;
            ps_cr = 1'b1;
        end else if (b == rbasp_pkg::CH_LF) begin
            ps_bad = 1'b1;
        end else begin
            if (ps_cr) begin
                ps_bad = 1'b1;
                ps_cr = 1'b0;
            end
            if (b == rbasp_pkg::CH_MINUS) begin
                if (ps_minus || ps_digit) ps_bad = 1'b1;
                ps_minus = 1'b1;
            end else if (b >= rbasp_pkg::CH_ZERO && b <= rbasp_pkg::CH_NINE) begin
                ps_digit = 1'b1;
                if (ps_accum > rbasp_pkg::ACCUM_CAP_DIV10) ps_accum = rbasp_pkg::ACCUM_CAP;
                else begin
                    ps_accum = ps_accum * 34'd10 + 34'(b - rbasp_pkg::CH_ZERO);
                    if (ps_accum > rbasp_pkg::ACCUM_CAP) ps_accum = rbasp_pkg::ACCUM_CAP;
                end
            end else begin
                ps_bad = 1'b1;
            end
        end
    endtask

    task automatic parse_byte(logic [7:0] b);
        logic [4:0] lvl;
        logic       d;
        if (ps_halted) begin
            post(rbasp_pkg::K_NONE, 32'd0, 5'd0, 1'b0, rbasp_pkg::E_TYPE);
            return;
        end
        case (ps_phase)
            rbasp_pkg::PH_TYPE: begin
                if (b == rbasp_pkg::CH_STAR && ps_depth >= 5'(DEPTH))
                    post_err(rbasp_pkg::E_DEEP);
                else if (b == rbasp_pkg::CH_DOLLAR || b == rbasp_pkg::CH_STAR) begin
                    ps_is_array = (b == rbasp_pkg::CH_STAR);
                    ps_accum = '0;
                    ps_minus = 1'b0; ps_digit = 1'b0; ps_bad = 1'b0; ps_cr = 1'b0;
                    ps_phase = rbasp_pkg::PH_LINE;
                    post(rbasp_pkg::K_NONE, 32'd0, ps_depth, 1'b0, rbasp_pkg::E_TYPE);
                end else post_err(rbasp_pkg::E_TYPE);
            end
            rbasp_pkg::PH_LINE: begin
                if (b == rbasp_pkg::CH_LF && ps_cr) end_line();
                else begin
                    line_char(b);
                    post(rbasp_pkg::K_NONE, 32'd0, ps_depth, 1'b0, rbasp_pkg::E_TYPE);
                end
            end
            rbasp_pkg::PH_PAYLOAD: begin
                ps_left = ps_left - 32'd1;
                if (ps_left == 32'd0) ps_phase = rbasp_pkg::PH_TERM_CR;
                post(rbasp_pkg::K_PAYLOAD, {24'd0, b}, ps_depth, 1'b0, rbasp_pkg::E_TYPE);
            end
            rbasp_pkg::PH_TERM_CR: begin
                ps_term_bad = (b != rbasp_pkg::CH_CR);
                ps_phase = rbasp_pkg::PH_TERM_LF;
                post(rbasp_pkg::K_NONE, 32'd0, ps_depth, 1'b0, rbasp_pkg::E_TYPE);
            end
            default: begin
                if (ps_term_bad || b != rbasp_pkg::CH_LF) post_err(rbasp_pkg::E_UNTERM);
                else begin
                    ps_phase = rbasp_pkg::PH_TYPE;
                    lvl = ps_depth;
                    d = close_elements();
                    post(rbasp_pkg::K_BULKEND, 32'd0, lvl, d, rbasp_pkg::E_TYPE);
                end
            end
        endcase
    endtask

    // stimulus building
    task automatic put_byte(logic [7:0] b);
        bytes_out = {bytes_out, b};
    endtask

    task automatic push_str(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic push_len(logic [7:0] prefix, int unsigned v);
        put_byte(prefix);
        if (v == 0 && $urandom_range(0, 3) == 0) push_str("-");
        repeat ($urandom_range(0, 4) == 0 ? $urandom_range(1, 2) : 0) push_str("0");
        push_str($sformatf("%0d\r\n", v));
    endtask

    task automatic push_bulk(int unsigned n);
        push_len(rbasp_pkg::CH_DOLLAR, n);
        repeat (n) put_byte(8'($urandom_range(0, 255)));
        push_str("\r\n");
    endtask

    task automatic gen_value(int d);
        int unsigned r, n;
        r = $urandom_range(0, 9);
        if (d < DEPTH && r < 3) begin
            n = (d < 3) ? $urandom_range(0, 3) : $urandom_range(0, 1);
            if (n > lim_array) n = lim_array;
            push_len(rbasp_pkg::CH_STAR, n);
            repeat (n) gen_value(d + 1);
        end else if (r == 3) begin
            push_str("$-1\r\n");
        end else begin
            n = $urandom_range(0, 6);
            if (n > lim_bulk) n = lim_bulk;
            push_bulk(n);
        end
    endtask

    task automatic gen_messages(int budget);
        while (bytes_out.size() < budget) gen_value(0);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (bytes_out.size() != 0 || i_valid || events_due.size() != 0);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        if (idx == rbasp_pkg::REG_BULK_LIMIT) lim_bulk = val;
        else lim_array = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cyc);
        err_cnt++;
    endtask

    // sender
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || took_cnt == sent_cnt)) begin
            if (snd_gap > 0) begin
                snd_gap--;
                i_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 24) == 0) begin
                snd_gap = $urandom_range(1, 18) - 1;
                i_valid <= 1'b0;
            end else if (bytes_out.size() > 0) begin
                i_byte_in <= bytes_out.pop_front();
                i_valid <= 1'b1;
                sent_cnt++;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always begin
        @(hold_go);
        hold_on = 1'b1;
        repeat (HOLD_CYC) @(negedge i_clk);
        hold_on = 1'b0;
    end

    // receiver
    always @(negedge i_clk) begin
        if (hold_on) begin
            i_stall <= 1'b1;
        end else if (rcv_gap > 0) begin
            rcv_gap--;
            i_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 19) == 0) begin
            rcv_gap = $urandom_range(1, 18) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_event ev;
        cyc++;
        if (cyc > CYC_LIMIT) begin
            $display("timeout at cycle %0d", cyc);
            $display("FAILED: results differ");
            $finish;
        end
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                took_cnt++;
                parse_byte(i_byte_in);
            end
            if (o_valid && !i_stall) begin
                if (events_due.size() == 0) begin
                    report("unexpected transfer", 32'(o_event_kind), 32'd0);
                end else begin
                    ev = events_due.pop_front();
                    if (o_event_kind != ev.kind)
                        report("kind", 32'(o_event_kind), 32'(ev.kind));
                    if (o_event_value != ev.value)
                        report("value", o_event_value, ev.value);
                    if (o_nest_level != ev.level)
                        report("level", 32'(o_nest_level), 32'(ev.level));
                    if (o_message_done != ev.done)
                        report("done", 32'(o_message_done), 32'(ev.done));
                    if (o_error_code != ev.err)
                        report("error", 32'(o_error_code), 32'(ev.err));
                end
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        push_str("$0\r\n\r\n");
        push_str("$-1\r\n");
        push_str("*0\r\n");
        push_str("*-0\r\n");
        push_str("$-0\r\n\r\n");
        push_str("$0004\r\n");
        put_byte(8'h00); put_byte(8'hff);
        put_byte(rbasp_pkg::CH_CR); put_byte(rbasp_pkg::CH_LF);
        push_str("\r\n");
        push_str("*3\r\n$1\r\n$\r\n*0\r\n$-1\r\n");
        push_str("*2\r\n*1\r\n*1\r\n$0\r\n\r\n$1\r\n*\r\n");
        repeat (DEPTH) push_str("*1\r\n");
        push_str("$2\r\nok\r\n");
        wait_idle();

        gen_messages(80);
        wait_idle();

        // widest limits, with a long receiver hold-off while bytes keep coming
        write_reg(rbasp_pkg::REG_BULK_LIMIT, 32'hffff_ffff);
        write_reg(rbasp_pkg::REG_ARRAY_LIMIT, 32'hffff_ffff);
        gen_messages(80);
        repeat (10) @(negedge i_clk);
        -> hold_go;
        wait_idle();

        // zero limits leave only empty items
        write_reg(rbasp_pkg::REG_BULK_LIMIT, 32'd0);
        write_reg(rbasp_pkg::REG_ARRAY_LIMIT, 32'd0);
        gen_messages(30);
        wait_idle();

        write_reg(rbasp_pkg::REG_BULK_LIMIT, $urandom_range(1, 8));
        write_reg(rbasp_pkg::REG_ARRAY_LIMIT, $urandom_range(1, 4));
        gen_messages(80);
        wait_idle();

        // last part: no idling, one random error then halted bytes
        quiet = 1;
        write_reg(rbasp_pkg::REG_ARRAY_LIMIT, 32'd16);
        gen_messages(30);
        case ($urandom_range(0, 6))
            0: push_str("+OK\r\n");
            1: case ($urandom_range(0, 5))
                0: push_str("$\r\n");
                1: push_str("$+5\r\n");
                2: push_str("$1 2\r\n");
                3: push_str("$--1\r\n");
                4: push_str("$-2\r\n");
                default: push_str("$5\r5\r\n");
            endcase
            2: push_str("$99999999999999999999\r\n");
            3: begin
                repeat (DEPTH) push_str("*1\r\n");
                push_str("*");
            end
            4: push_str($urandom_range(0, 1) ? "*-1\r\n" : "*x\r\n");
            5: push_str("*99999999999\r\n");
            default: push_str($urandom_range(0, 1) ? "$2\r\nabx\n" : "$2\r\nab\rx");
        endcase
        repeat (20) put_byte(8'($urandom_range(0, 255)));

        do @(negedge i_clk);
        while (bytes_out.size() != 0 || i_valid || events_due.size() != 0);
        repeat (30) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
